// ===== rtl/lru_page_replacement_assert.svh =====
// Assertion macros shared by the LRU page replacement checker.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define LRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LRU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lru_pkg.sv =====
// Package for the LRU page replacement block: sizes and beat types.
`default_nettype none

package lru_pkg;

	localparam int FRAMES     = 8;
	localparam int PAGE_BITS  = 20;
	localparam int COUNT_BITS = 32;
	localparam int RANK_BITS  = $clog2(FRAMES);
	localparam int FIDX_BITS  = 3;
	localparam int TOTAL_BITS = 32;
	localparam int CFG_BITS   = 4;

	localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(FRAMES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [19:0] page_number;
		logic        last_reference;
	} ref_item_t;

	typedef struct packed {
		logic                  page_fault;
		logic [FIDX_BITS-1:0]  frame_index;
		logic [TOTAL_BITS-1:0] fault_total;
		logic                  run_done;
	} res_item_t;

endpackage

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Top level of the fully associative LRU page replacement block.
`default_nettype none

// LRU page replacement over a fully associative table of eight frames. Each
// beat on the reference channel carries one page number; each beat on the
// result channel reports hit or fault, the frame that now holds the page and
// the saturating fault total of the current run. A reference marked last ends
// the run: after its result the table and the fault total start over. The
// block takes one reference per clock while the result channel does not stall;
// an accepted reference lands in the input register and its answer then in
// the result register. The tag compare, empty/victim pick and recency update
// over all frames are combinational and sit between the input and result
// registers. While a result beat is stalled the input register holds and the
// reference channel stalls with it. The frames_in_use register is written
// through the cfg channel while the block is idle; the block refuses a write
// while the input register holds a reference. Zero acts as one frame, values
// above eight act as eight.
module lru_page_replacement (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// reference channel
	input  wire logic                         ref_valid,
	output      logic                         ref_stall,
	input  wire lru_pkg::ref_item_t           ref_item,
	// result channel
	output      logic                         res_valid,
	input  wire logic                         res_stall,
	output      lru_pkg::res_item_t           res_item,
	// configuration write channel (frames_in_use)
	input  wire logic                         cfg_valid,
	output      logic                         cfg_ready,
	input  wire logic [lru_pkg::CFG_BITS-1:0] cfg_data
);
	import lru_pkg::*;

	// Configuration
	logic [CFG_BITS-1:0] frames_in_use_q;

	// Input stage
	ref_item_t item_s1;
	logic      valid_s1;

	// Frame table
	logic [PAGE_BITS-1:0] page_q  [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [RANK_BITS-1:0] rank_q  [FRAMES];
	logic [COUNT_BITS-1:0] fault_cnt_q;

	// Result register
	res_item_t res_q;
	logic      res_valid_q;

	// Lookup results
	logic [FRAMES-1:0]    act_mask;
	logic [FRAMES-1:0]    hit_vec;
	logic                 hit_any, empty_any, victim_any;
	logic [FIDX_BITS-1:0] hit_idx, empty_idx, victim_idx, sel_idx;
	logic [RANK_BITS-1:0] victim_rank, sel_rank;
	logic                 fault, was_valid;
	logic [COUNT_BITS-1:0] fault_cnt_nxt;
	logic [PAGE_BITS-1:0] page_s1;

	logic advance, fire_s1, load_s1;

	// The stage moves on when the result register is empty or being drained.
	assign advance   = !res_valid_q || !res_stall;
	assign fire_s1   = valid_s1 && advance;
	assign ref_stall = valid_s1 && !advance;
	assign load_s1   = ref_valid && !ref_stall;

	// Config is written only while idle; refuse it while a reference is in flight.
	assign cfg_ready = !valid_s1;

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign page_s1 = item_s1.page_number[PAGE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// Lookup: match, lowest empty active frame, least recent active frame.
	always_comb begin
		hit_any     = 1'b0;
		hit_idx     = '0;
		empty_any   = 1'b0;
		empty_idx   = '0;
		victim_any  = 1'b0;
		victim_idx  = '0;
		victim_rank = '0;
		for (int i = 0; i < FRAMES; i++) begin
			// zero behaves as one frame; anything past FRAMES covers all
			act_mask[i] = (frames_in_use_q == '0) ? (i == 0) : (int'(frames_in_use_q) > i);
			hit_vec[i]  = act_mask[i] && valid_q[i] && (page_q[i] == page_s1);
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = FIDX_BITS'(i);
			end
			if (act_mask[i] && !valid_q[i]) begin
				empty_any = 1'b1;
				empty_idx = FIDX_BITS'(i);
			end
		end
		// ranks of valid frames are distinct; strict compare keeps the lowest index
		for (int i = 0; i < FRAMES; i++) begin
			if (act_mask[i] && valid_q[i] && (!victim_any || rank_q[i] > victim_rank)) begin
				victim_any  = 1'b1;
				victim_idx  = FIDX_BITS'(i);
				victim_rank = rank_q[i];
			end
		end

		fault     = !hit_any;
		sel_idx   = hit_any ? hit_idx : (empty_any ? empty_idx : victim_idx);
		was_valid = hit_any || !empty_any;
		sel_rank  = rank_q[sel_idx];

		fault_cnt_nxt = fault_cnt_q;
		if (fault && fault_cnt_q != COUNT_MAX) begin
			fault_cnt_nxt = fault_cnt_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= ref_item;
		end
	end

	// Frame table control state: valid bits, recency ranks, fault count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fault_cnt_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire_s1) begin
			if (item_s1.last_reference) begin
				// run closes: table and count start over
				valid_q     <= '0;
				fault_cnt_q <= '0;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= '0;
				end
			end else begin
				fault_cnt_q      <= fault_cnt_nxt;
				valid_q[sel_idx] <= 1'b1;
				// frames more recent than the touched one age by one; a fill ages all
				for (int i = 0; i < FRAMES; i++) begin
					if (FIDX_BITS'(i) == sel_idx) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (!was_valid || rank_q[i] < sel_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_BITS'(1);
					end
				end
			end
		end
	end

	// Page tags: written on a fault only, no reset.
	always_ff @(posedge clk) begin
		if (fire_s1 && fault) begin
			page_q[sel_idx] <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q.page_fault  <= fault;
			res_q.frame_index <= sel_idx;
			res_q.fault_total <= fault_cnt_nxt[TOTAL_BITS-1:0];
			res_q.run_done    <= item_s1.last_reference;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lru_checker.sv =====
// Port-level checker for the LRU page replacement block, with its bind.
`default_nettype none

`include "lru_page_replacement_assert.svh"

module lru_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               ref_stall,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire lru_pkg::res_item_t res_item
);
	import lru_pkg::*;

	// a stalled result beat holds
	`LRU_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_item), "result beat changed while stalled")

	// every run opens with a fault, so no result reports a zero total
	`LRU_ASSERT(a_total_nonzero, res_valid |-> res_item.fault_total != '0, "result with zero fault total")

	// backpressure on references only comes from a stalled result
	`LRU_ASSERT(a_stall_cause, ref_stall |-> res_valid && res_stall, "reference stalled without result stall")

	// no result beat while in reset
	`LRU_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind lru_page_replacement lru_checker u_lru_checker (.*);

`default_nettype wire

// ===== sim/lru_page_replacement_checker.sv =====
// Checker for the LRU page replacement block: predicts each result beat and compares.
module lru_page_replacement_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         ref_valid,
	input  wire logic                         ref_stall,
	input  wire lru_pkg::ref_item_t           ref_item,
	input  wire logic                         res_valid,
	input  wire logic                         res_stall,
	input  wire lru_pkg::res_item_t           res_item,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [lru_pkg::CFG_BITS-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lru_pkg::*;

	// shadow of the frame table
	logic [CFG_BITS-1:0]   frames_cfg;
	logic [PAGE_BITS-1:0]  page_of [FRAMES];
	logic                  held    [FRAMES];
	int                    age     [FRAMES];
	logic [COUNT_BITS-1:0] miss_total;

	res_item_t outcome_q [$];

	// Move frame f to the front of the recency order.
	function automatic void promote(int f, logic was_held);
		int i;
		for (i = 0; i < FRAMES; i++) begin
			if (i != f && held[i] && (!was_held || age[i] < age[f]))
				age[i]++;
		end
		age[f]  = 0;
		held[f] = 1'b1;
	endfunction

	// Apply one reference to the shadow table and return its outcome.
	function automatic res_item_t replace_page(ref_item_t beat);
		res_item_t out;
		int        active, hit, empty, victim, i;
		logic      miss;
		active = int'(frames_cfg);
		if (active < 1)
			active = 1;
		if (active > FRAMES)
			active = FRAMES;
		hit    = -1;
		empty  = -1;
		victim = -1;
		for (i = 0; i < active; i++) begin
			if (held[i]) begin
				if (hit < 0 && page_of[i] == beat.page_number)
					hit = i;
				if (victim < 0 || age[i] > age[victim])
					victim = i;
			end else if (empty < 0) begin
				empty = i;
			end
		end
		miss = (hit < 0);
		if (!miss) begin
			promote(hit, 1'b1);
		end else begin
			if (miss_total != COUNT_MAX)
				miss_total++;
			if (empty >= 0) begin
				hit = empty;
				promote(hit, 1'b0);
			end else begin
				hit = victim;
				promote(hit, 1'b1);
			end
			page_of[hit] = beat.page_number;
		end
		out.page_fault  = miss;
		out.frame_index = FIDX_BITS'(hit);
		out.fault_total = miss_total[TOTAL_BITS-1:0];
		out.run_done    = beat.last_reference;
		if (beat.last_reference) begin
			for (i = 0; i < FRAMES; i++) begin
				held[i] = 1'b0;
				age[i]  = 0;
			end
			miss_total = '0;
		end
		return out;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		int        i;
		if (!arst_n) begin
			frames_cfg = CFG_RESET;
			for (i = 0; i < FRAMES; i++) begin
				page_of[i] = '0;
				held[i]    = 1'b0;
				age[i]     = 0;
			end
			miss_total = '0;
			outcome_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				frames_cfg = cfg_data;
			// result side first: a beat leaving now stems from an earlier reference
			if (res_valid && !res_stall) begin
				if (outcome_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat, expected none actual %p",
						$time, res_item);
				end else begin
					want = outcome_q.pop_front();
					if (res_item.page_fault !== want.page_fault ||
						res_item.frame_index !== want.frame_index ||
						res_item.fault_total !== want.fault_total ||
						res_item.run_done !== want.run_done) begin
						fail_count++;
						$display("%0t: mismatch expected %p actual %p",
							$time, want, res_item);
					end
				end
			end
			if (ref_valid && !ref_stall)
				outcome_q.push_back(replace_page(ref_item));
			pending = outcome_q.size();
		end
	end

endmodule

// ===== sim/lru_page_replacement_test.sv =====
// Testbench top for the LRU page replacement block: clock, reset, stimulus and verdict.
module lru_page_replacement_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lru_pkg::*;

	localparam int REF_TARGET = 1250;
	localparam int POOL_MAX   = 12;

	logic                clk;
	logic                arst_n;
	logic                ref_valid;
	logic                ref_stall;
	ref_item_t           ref_beat;
	logic                res_valid;
	logic                res_stall;
	res_item_t           res_beat;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] cfg_data;

	int   fail_count;
	int   pending;
	logic calm;     // when set, neither side idles
	int   sent;

	lru_page_replacement u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.ref_valid (ref_valid),
		.ref_stall (ref_stall),
		.ref_item  (ref_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_beat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lru_page_replacement_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ref_valid  (ref_valid),
		.ref_stall  (ref_stall),
		.ref_item   (ref_beat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_beat),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop, several times the longest run the stimulus can produce.
	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Idle length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One reference beat. Valid stays high straight into the next beat when
	// no gap is drawn, so it never drops and rises within one step.
	task automatic send_ref(input logic [PAGE_BITS-1:0] page, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			ref_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		ref_beat.page_number = page;
		ref_beat.last_reference = last;
		ref_valid = 1'b1;
		do @(posedge clk); while (ref_stall);
		@(negedge clk);
		sent++;
	endtask

	// Stop sending until every result is out; the extra cycles cover the
	// two-stage pipe so the block is truly idle.
	task automatic wait_drained();
		ref_valid = 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Register write; only called with the block idle.
	task automatic write_frames(input logic [CFG_BITS-1:0] value);
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side back-pressure, changed only on the falling edge.
	initial begin
		int hold;
		int n;
		hold = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				res_stall = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
				res_stall = (n > 0);
				hold = (n > 0) ? n - 1 : 0;
			end else begin
				res_stall = 1'b0;
			end
		end
	end

	initial begin
		logic [PAGE_BITS-1:0] pool [POOL_MAX];
		logic [PAGE_BITS-1:0] pg;
		int                   pool_size, run_len, k, r;
		logic                 end_run, last;

		ref_valid = 1'b0;
		ref_beat  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		calm      = 1'b0;
		sent      = 0;
		// reset falls once every process is waiting, so its edge is seen
		arst_n    = 1'b1;
		#1;
		arst_n    = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed ---
		// full table: page zero twice (hit), all-ones page, fill the rest,
		// then two evictions and a closing reference
		write_frames(CFG_BITS'(8));
		send_ref('0, 1'b0);
		send_ref('0, 1'b0);
		send_ref('1, 1'b0);
		for (k = 1; k <= 6; k++)
			send_ref(PAGE_BITS'(k), 1'b0);
		send_ref(PAGE_BITS'(7), 1'b0);
		send_ref('0, 1'b0);
		send_ref('1, 1'b1);

		// register zero behaves as a single frame
		wait_drained();
		write_frames('0);
		send_ref(PAGE_BITS'(5), 1'b0);
		send_ref(PAGE_BITS'(5), 1'b0);
		send_ref(PAGE_BITS'(6), 1'b0);
		send_ref(PAGE_BITS'(5), 1'b1);

		// two frames, then widened mid-run past the frame count:
		// the old pages stay put and the new frames fill from the bottom
		wait_drained();
		write_frames(CFG_BITS'(2));
		send_ref(PAGE_BITS'(10), 1'b0);
		send_ref(PAGE_BITS'(11), 1'b0);
		send_ref(PAGE_BITS'(12), 1'b0);
		wait_drained();
		write_frames('1);
		send_ref(PAGE_BITS'(10), 1'b0);
		send_ref(PAGE_BITS'(11), 1'b0);
		send_ref(PAGE_BITS'(12), 1'b1);

		// --- random runs ---
		// Each run draws a small working set so that hits, fills and LRU
		// evictions all occur; some references flip one bit of a working-set
		// page or are wholly random. A run that does not end with a last
		// beat carries its table into the next run.
		while (sent < REF_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) != 0) begin
				wait_drained();
				r = $urandom_range(0, 9);
				if (r == 0)
					write_frames('0);
				else if (r == 1)
					write_frames(CFG_BITS'($urandom_range(9, 15)));
				else if (r == 2)
					write_frames(CFG_BITS'(8));
				else
					write_frames(CFG_BITS'($urandom_range(1, 8)));
			end
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 30);
			pool_size = $urandom_range(1, POOL_MAX);
			for (k = 0; k < pool_size; k++)
				pool[k] = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
			end_run = ($urandom_range(0, 4) != 0);
			for (k = 0; k < run_len; k++) begin
				r = $urandom_range(0, 99);
				pg = pool[$urandom_range(0, pool_size - 1)];
				if (r >= 92)
					pg = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
				else if (r >= 85)
					pg = pg ^ (PAGE_BITS'(1) << $urandom_range(0, PAGE_BITS - 1));
				last = ((k == run_len - 1) && end_run) || ($urandom_range(0, 99) == 0);
				// sender holds off mid-run until the pipe is empty
				if (k == run_len / 2 && $urandom_range(0, 7) == 0)
					wait_drained();
				send_ref(pg, last);
			end
		end

		// --- drain and verdict ---
		ref_valid = 1'b0;
		calm = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lru_pkg.sv
rtl/lru_page_replacement.sv
rtl/lru_checker.sv
sim/lru_page_replacement_checker.sv
sim/lru_page_replacement_test.sv
